FILE: src/price_level_fifo_matcher_unit_defines.svh
// assertion macros used by the price level matcher datapath
`ifndef PRICE_LEVEL_FIFO_MATCHER_UNIT_DEFINES_SVH
`define PRICE_LEVEL_FIFO_MATCHER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define PLFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plfm assertion failed");
// next-cycle implication, disabled during reset
`define PLFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plfm assertion failed");
`else
`define PLFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLFM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/plfm_pkg.sv
// types, constants and helpers of the price level matcher
`timescale 1ns / 1ps
`default_nettype none

package plfm_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_DEPTH   = QUEUE_DEPTH + 1;
    localparam int RIDX_W      = $clog2(RES_DEPTH);
    localparam int RCNT_W      = $clog2(RES_DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int QTY_W    = 31;
    localparam int PRICE_W  = 32;
    localparam int RKIND_W  = 3;
    localparam int STAT_W   = 2;
    localparam int TOT_W    = 36;
    localparam int LQ_W     = TOT_W + 1;
    localparam int OCNT_W   = 6;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MATCH  = 2'd2
    } t_op;

    typedef enum logic [RKIND_W-1:0] {
        RK_ADD_ACK    = 3'd0,
        RK_CANCEL_ACK = 3'd1,
        RK_FILL       = 3'd2,
        RK_RETIRED    = 3'd3,
        RK_MATCH_DONE = 3'd4
    } t_res_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CANCEL,
        S_MATCH,
        S_RES_RD,
        S_RES_LD,
        S_OUT_WAIT
    } t_state;

    // one buffered result, totals are attached at the output
    typedef struct packed {
        t_res_kind         kind;
        t_status           status;
        logic [ID_W-1:0]   rid;
        logic [QTY_W-1:0]  tq;
        logic              retired;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic do_add;
        logic scan_cancel;
        logic scan_match;
        logic push_miss;
        logic push_done;
        logic res_rd;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cancel_hit;
        logic cancel_miss;
        logic match_end;
        logic res_empty;
        logic out_taken;
    } t_sts;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: src/plfm_in_if.sv
// input order channel
`timescale 1ns / 1ps
`default_nettype none

interface plfm_in_if import plfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    ord_key;
    logic [QTY_W-1:0]   quantity;
    logic               order_active;
    logic               aggr_side;

    modport source (output valid, kind, ord_key, quantity, order_active,
                    aggr_side, input ready);
    modport sink   (input valid, kind, ord_key, quantity, order_active,
                    aggr_side, output ready);
endinterface

`default_nettype wire

FILE: src/plfm_out_if.sv
// result channel
`timescale 1ns / 1ps
`default_nettype none

interface plfm_out_if import plfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RKIND_W-1:0] result_kind;
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    buyer_key;
    logic [ID_W-1:0]    seller_key;
    logic [ID_W-1:0]    resting_key;
    logic [QTY_W-1:0]   trade_quantity;
    logic [PRICE_W-1:0] fill_price;
    logic               resting_retired;
    logic [TOT_W-1:0]   level_qty;
    logic [OCNT_W-1:0]  live_orders;
    logic               last;

    modport source (output valid, result_kind, status, buyer_key, seller_key,
                    resting_key, trade_quantity, fill_price, resting_retired,
                    level_qty, live_orders, last, input ready);
    modport sink   (input valid, result_kind, status, buyer_key, seller_key,
                    resting_key, trade_quantity, fill_price, resting_retired,
                    level_qty, live_orders, last, output ready);
endinterface

`default_nettype wire

FILE: src/plfm_cfg_if.sv
// level price write channel
`timescale 1ns / 1ps
`default_nettype none

interface plfm_cfg_if import plfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/plfm_ctrl.sv
// sequencing state machine of the price level matcher
`timescale 1ns / 1ps
`default_nettype none

module plfm_ctrl import plfm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [KIND_W-1:0] i_in_kind,
    input  wire t_sts              i_sts,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_kind)
                        OP_ADD:    n_state = S_ADD;
                        OP_CANCEL: n_state = S_CANCEL;
                        OP_MATCH:  n_state = S_MATCH;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD:    n_state = S_RES_RD;
            S_CANCEL: begin
                if (i_sts.cancel_hit || i_sts.cancel_miss) begin
                    n_state = S_RES_RD;
                end
            end
            S_MATCH: begin
                if (i_sts.match_end) begin
                    n_state = S_RES_RD;
                end
            end
            S_RES_RD: n_state = S_RES_LD;
            S_RES_LD: n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.res_empty ? S_IDLE : S_RES_RD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // commands, no transfer taken while in reset
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = i_rst_n;
                o_cmd.latch = i_in_valid && i_rst_n;
            end
            S_ADD:    o_cmd.do_add = 1'b1;
            S_CANCEL: begin
                o_cmd.scan_cancel = 1'b1;
                o_cmd.push_miss   = i_sts.cancel_miss;
            end
            S_MATCH: begin
                o_cmd.scan_match = 1'b1;
                o_cmd.push_done  = i_sts.match_end;
            end
            S_RES_RD: o_cmd.res_rd   = 1'b1;
            S_RES_LD: o_cmd.out_load = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/plfm_datapath.sv
// order ring, level totals, result buffer and output register
`timescale 1ns / 1ps
`default_nettype none
`include "price_level_fifo_matcher_unit_defines.svh"

module plfm_datapath import plfm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    // input item fields
    input  wire logic [ID_W-1:0]    i_ord_key,
    input  wire logic [QTY_W-1:0]   i_quantity,
    input  wire logic               i_order_active,
    input  wire logic               i_aggr_side,
    // level price write
    input  wire logic               i_cfg_valid,
    input  wire logic [PRICE_W-1:0] i_cfg_data,
    // result
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [RKIND_W-1:0]      o_result_kind,
    output logic [STAT_W-1:0]       o_status,
    output logic [ID_W-1:0]         o_buyer_key,
    output logic [ID_W-1:0]         o_seller_key,
    output logic [ID_W-1:0]         o_resting_key,
    output logic [QTY_W-1:0]        o_trade_quantity,
    output logic [PRICE_W-1:0]      o_fill_price,
    output logic                    o_resting_retired,
    output logic [TOT_W-1:0]        o_level_qty,
    output logic [OCNT_W-1:0]       o_live_orders,
    output logic                    o_last
);

    // ring storage
    logic [ID_W-1:0]  mem_id   [QUEUE_DEPTH];
    logic [QTY_W-1:0] mem_rem  [QUEUE_DEPTH];
    logic             mem_live [QUEUE_DEPTH];
    // result buffer
    t_res             mem_res  [RES_DEPTH];

    // level state
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_live_cnt, n_live_cnt;
    logic [LQ_W-1:0]  r_lq, n_lq;
    logic [PRICE_W-1:0] r_level_price;

    // latched item
    logic [ID_W-1:0]  r_op_id;
    logic [QTY_W-1:0] r_op_qty;
    logic             r_op_act;
    logic             r_side;
    logic [QTY_W-1:0] r_matched, n_matched;
    logic [CNT_W-1:0] r_occ_start;

    // scan read stream
    logic [PTR_W-1:0] r_issue_ptr;
    logic [CNT_W-1:0] r_issue_cnt;
    logic             r_rd_vld;
    logic [PTR_W-1:0] r_rd_addr;
    logic [ID_W-1:0]  r_rd_id;
    logic [QTY_W-1:0] r_rd_rem;
    logic             r_rd_live;

    // result buffer pointers and output register
    logic [RCNT_W-1:0] r_res_wcnt;
    logic [RCNT_W-1:0] r_res_rcnt;
    t_res              r_res_q;
    t_res              r_out;
    logic              r_out_last;
    logic              r_out_vld;

    // combinational controls
    logic             full;
    logic             scan_done;
    logic             cancel_hit;
    logic             match_end;
    logic             match_eval;
    logic             issue_en;
    logic [QTY_W-1:0] left;
    logic [QTY_W-1:0] tq;
    logic [QTY_W-1:0] new_rem;
    logic             we_id, we_rem, we_live;
    logic [PTR_W-1:0] w_addr;
    logic [QTY_W-1:0] w_rem;
    logic             w_live;
    logic             push;
    t_res             push_data;

    // scan status
    always_comb begin
        full       = (r_occ == CNT_W'(QUEUE_DEPTH));
        scan_done  = !r_rd_vld && (r_issue_cnt == r_occ_start);
        cancel_hit = r_rd_vld && r_rd_live && (r_rd_id == r_op_id);
        match_end  = (r_matched >= r_op_qty) || scan_done;
        match_eval = i_cmd.scan_match && !match_end && r_rd_vld;
        issue_en   = ((i_cmd.scan_cancel && !cancel_hit) || (i_cmd.scan_match && !match_end))
                     && (r_issue_cnt != r_occ_start);
        left       = r_op_qty - r_matched;
        tq         = (r_rd_rem < left) ? r_rd_rem : left;
        new_rem    = r_rd_rem - tq;
    end

    always_comb begin
        o_sts.cancel_hit  = cancel_hit;
        o_sts.cancel_miss = scan_done;
        o_sts.match_end   = match_end;
        o_sts.res_empty   = (r_res_rcnt == r_res_wcnt);
        o_sts.out_taken   = r_out_vld && i_out_ready;
    end

    // ring updates, level totals and result pushes
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_live_cnt = r_live_cnt;
        n_lq       = r_lq;
        n_matched  = r_matched;
        we_id      = 1'b0;
        we_rem     = 1'b0;
        we_live    = 1'b0;
        w_addr     = r_rd_addr;
        w_rem      = new_rem;
        w_live     = 1'b0;
        push       = 1'b0;
        push_data  = '{kind: RK_ADD_ACK, status: ST_OK, rid: '0, tq: '0, retired: 1'b0};

        if (i_cmd.do_add) begin
            push = 1'b1;
            if (full) begin
                push_data.status = ST_FULL;
            end else begin
                we_id   = 1'b1;
                we_rem  = 1'b1;
                we_live = 1'b1;
                w_addr  = r_tail;
                w_rem   = r_op_qty;
                w_live  = r_op_act && (r_op_qty != '0);
                n_tail  = ring_next(r_tail);
                n_occ   = r_occ + 1'b1;
                if (w_live) begin
                    n_live_cnt = r_live_cnt + 1'b1;
                    n_lq       = r_lq + LQ_W'(r_op_qty);
                end
            end
        end

        if (i_cmd.scan_cancel && cancel_hit) begin
            we_live        = 1'b1;
            n_live_cnt     = r_live_cnt - 1'b1;
            n_lq           = r_lq - LQ_W'(r_rd_rem);
            push           = 1'b1;
            push_data.kind = RK_CANCEL_ACK;
        end

        if (i_cmd.push_miss) begin
            push             = 1'b1;
            push_data.kind   = RK_CANCEL_ACK;
            push_data.status = ST_NOT_FOUND;
        end

        // head entry of a match: retire a dead one, fill a live one
        if (match_eval) begin
            push          = 1'b1;
            push_data.rid = r_rd_id;
            if (!r_rd_live) begin
                push_data.kind    = RK_RETIRED;
                push_data.retired = 1'b1;
                n_head            = ring_next(r_head);
                n_occ             = r_occ - 1'b1;
            end else begin
                push_data.kind    = RK_FILL;
                push_data.tq      = tq;
                push_data.retired = (new_rem == '0);
                we_rem            = 1'b1;
                n_matched         = r_matched + tq;
                n_lq              = r_lq - LQ_W'(tq);
                if (new_rem == '0) begin
                    we_live    = 1'b1;
                    n_live_cnt = r_live_cnt - 1'b1;
                    n_head     = ring_next(r_head);
                    n_occ      = r_occ - 1'b1;
                end
            end
        end

        if (i_cmd.push_done) begin
            push           = 1'b1;
            push_data.kind = RK_MATCH_DONE;
            push_data.tq   = r_matched;
        end
    end

    // ring memory write and registered scan read
    always_ff @(posedge i_clk) begin
        if (we_id) begin
            mem_id[w_addr] <= r_op_id;
        end
        if (we_rem) begin
            mem_rem[w_addr] <= w_rem;
        end
        if (we_live) begin
            mem_live[w_addr] <= w_live;
        end
        if (issue_en) begin
            r_rd_id   <= mem_id[r_issue_ptr];
            r_rd_rem  <= mem_rem[r_issue_ptr];
            r_rd_live <= mem_live[r_issue_ptr];
            r_rd_addr <= r_issue_ptr;
        end
    end

    // result buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem_res[r_res_wcnt[RIDX_W-1:0]] <= push_data;
        end
        if (i_cmd.res_rd) begin
            r_res_q <= mem_res[r_res_rcnt[RIDX_W-1:0]];
        end
    end

    // item latch and output register load, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op_id     <= i_ord_key;
            r_op_qty    <= i_quantity;
            r_op_act    <= i_order_active;
            r_side      <= i_aggr_side;
            r_occ_start <= r_occ;
        end
        if (i_cmd.out_load) begin
            r_out      <= r_res_q;
            r_out_last <= ((r_res_rcnt + 1'b1) == r_res_wcnt);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_occ         <= '0;
            r_live_cnt    <= '0;
            r_lq          <= '0;
            r_level_price <= '0;
            r_matched     <= '0;
            r_issue_ptr   <= '0;
            r_issue_cnt   <= '0;
            r_rd_vld      <= 1'b0;
            r_res_wcnt    <= '0;
            r_res_rcnt    <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_occ      <= n_occ;
            r_live_cnt <= n_live_cnt;
            r_lq       <= n_lq;
            r_matched  <= n_matched;
            r_rd_vld   <= issue_en;
            if (i_cfg_valid) begin
                r_level_price <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_matched   <= '0;
                r_issue_ptr <= r_head;
                r_issue_cnt <= '0;
                r_res_wcnt  <= '0;
                r_res_rcnt  <= '0;
            end else begin
                if (issue_en) begin
                    r_issue_ptr <= ring_next(r_issue_ptr);
                    r_issue_cnt <= r_issue_cnt + 1'b1;
                end
                if (push) begin
                    r_res_wcnt <= r_res_wcnt + 1'b1;
                end
                if (i_cmd.out_load) begin
                    r_res_rcnt <= r_res_rcnt + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // output fields, totals taken from the settled level state
    always_comb begin
        o_out_valid       = r_out_vld;
        o_result_kind     = r_out.kind;
        o_status          = r_out.status;
        o_resting_key     = r_out.rid;
        o_trade_quantity  = r_out.tq;
        o_resting_retired = r_out.retired;
        o_last            = r_out_last;
        o_buyer_key       = '0;
        o_seller_key      = '0;
        o_fill_price      = '0;
        if (r_out.kind == RK_FILL) begin
            o_buyer_key  = r_side ? r_out.rid : r_op_id;
            o_seller_key = r_side ? r_op_id : r_out.rid;
            o_fill_price = r_level_price;
        end
        o_level_qty   = r_lq[LQ_W-1] ? '1 : r_lq[TOT_W-1:0];
        o_live_orders = OCNT_W'(r_live_cnt);
    end

    `PLFM_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(QUEUE_DEPTH))
    `PLFM_ASSERT_IMP(a_live_le_occ, i_clk, i_rst_n, 1'b1, r_live_cnt <= r_occ)
    `PLFM_ASSERT_IMP(a_res_bound, i_clk, i_rst_n, 1'b1, r_res_wcnt <= RCNT_W'(RES_DEPTH))
    `PLFM_ASSERT_NXT(a_add_grows, i_clk, i_rst_n, i_cmd.do_add && !full, r_occ == $past(r_occ) + 1'b1)

endmodule

`default_nettype wire

FILE: src/price_level_fifo_matcher_unit.sv
// top level of the price level matcher
// One price level of an order book: up to 32 resting orders in a ring,
// handled one input item at a time. A cancel scans the ring from the head
// at one entry per cycle, up to the occupancy at the item's start; a match
// walks the head at one entry per cycle. The ring is a memory with a
// registered read, which sets the one-entry-per-cycle pace. Results are
// held in a buffer until the item is fully handled, so that every result
// carries the final level totals; each result then goes through a buffer
// read and an output load, then waits on the output ready for its
// transfer. The next item is taken once the last result of the current
// one has transferred. The level price may be written at any time the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module price_level_fifo_matcher_unit import plfm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plfm_in_if.sink    i_in,
    plfm_out_if.source o_out,
    plfm_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // sequencing
    plfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // storage and arithmetic
    plfm_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_ord_key         (i_in.ord_key),
        .i_quantity        (i_in.quantity),
        .i_order_active    (i_in.order_active),
        .i_aggr_side       (i_in.aggr_side),
        .i_cfg_valid       (i_cfg.valid && in_ready),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_result_kind     (o_out.result_kind),
        .o_status          (o_out.status),
        .o_buyer_key       (o_out.buyer_key),
        .o_seller_key      (o_out.seller_key),
        .o_resting_key     (o_out.resting_key),
        .o_trade_quantity  (o_out.trade_quantity),
        .o_fill_price      (o_out.fill_price),
        .o_resting_retired (o_out.resting_retired),
        .o_level_qty       (o_out.level_qty),
        .o_live_orders     (o_out.live_orders),
        .o_last            (o_out.last)
    );

    // handshake ready lines, price writes only while idle
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = in_ready;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the price level matcher: directed table, ring overflow, then random orders, scoreboard checked
`timescale 1ns / 1ps

module tb_top;
    import plfm_pkg::*;

    localparam int WDOG_LIMIT = 5000;

    typedef struct {
        t_op         op;
        logic [31:0] oid;
        logic [30:0] qty;
        logic        act;
        logic        side;
    } t_order;

    typedef struct {
        t_res_kind   kind;
        t_status     status;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [31:0] rest_id;
        logic [30:0] tq;
        logic [31:0] price;
        logic        retired;
        logic [35:0] total;
        logic [5:0]  count;
        logic        last;
    } t_fill_rec;

    logic i_clk;
    logic i_rst_n;

    plfm_in_if  in_ch ();
    plfm_out_if out_ch ();
    plfm_cfg_if cfg_ch ();

    price_level_fifo_matcher_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // book mirror
    logic [31:0] book_ids [QUEUE_DEPTH];
    logic [30:0] book_rem [QUEUE_DEPTH];
    logic        book_live[QUEUE_DEPTH];
    int          book_head, book_tail, book_occ, book_cnt;
    logic [36:0] book_qty;
    logic [31:0] book_price;

    t_fill_rec   pending_q[$];
    int          errors;
    int          mismatches;
    int          idle_cycles;
    bit          done_flag;
    logic [31:0] used_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int ring_inc(int p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic t_fill_rec blank_rec(t_res_kind k);
        t_fill_rec r;
        r = '{k, ST_OK, 32'd0, 32'd0, 32'd0, 31'd0, 32'd0, 1'b0, 36'd0, 6'd0, 1'b0};
        return r;
    endfunction

    // compute the results of one order and update the mirror
    task automatic book_step(input t_order o);
        t_fill_rec rs[$];
        t_fill_rec r;
        logic [31:0] matched;
        logic [30:0] tq;
        int p;
        int n;
        if (o.op == OP_ADD) begin
            r = blank_rec(RK_ADD_ACK);
            if (book_occ >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                book_ids[book_tail]  = o.oid;
                book_rem[book_tail]  = o.qty;
                book_live[book_tail] = o.act && (o.qty != 0);
                if (book_live[book_tail]) begin
                    book_cnt++;
                    book_qty += o.qty;
                end
                book_tail = ring_inc(book_tail);
                book_occ++;
            end
            rs.insert(rs.size(), r);
        end else if (o.op == OP_CANCEL) begin
            r = blank_rec(RK_CANCEL_ACK);
            r.status = ST_NOT_FOUND;
            p = book_head;
            for (int i = 0; i < book_occ; i++) begin
                if (book_live[p] && book_ids[p] == o.oid) begin
                    book_live[p] = 1'b0;
                    book_cnt--;
                    book_qty -= book_rem[p];
                    r.status = ST_OK;
                    break;
                end
                p = ring_inc(p);
            end
            rs.insert(rs.size(), r);
        end else begin
            matched = 0;
            while (book_occ > 0 && matched < o.qty) begin
                p = book_head;
                if (!book_live[p]) begin
                    r = blank_rec(RK_RETIRED);
                    r.rest_id = book_ids[p];
                    r.retired = 1'b1;
                    rs.insert(rs.size(), r);
                    book_head = ring_inc(book_head);
                    book_occ--;
                    continue;
                end
                tq = (book_rem[p] < o.qty - matched) ? book_rem[p] : 31'(o.qty - matched);
                book_rem[p] -= tq;
                matched += tq;
                book_qty -= tq;
                r = blank_rec(RK_FILL);
                r.buy_id  = o.side ? book_ids[p] : o.oid;
                r.sell_id = o.side ? o.oid : book_ids[p];
                r.rest_id = book_ids[p];
                r.tq      = tq;
                r.price   = book_price;
                r.retired = (book_rem[p] == 0);
                rs.insert(rs.size(), r);
                if (book_rem[p] == 0) begin
                    book_live[p] = 1'b0;
                    book_cnt--;
                    book_head = ring_inc(book_head);
                    book_occ--;
                end
            end
            r = blank_rec(RK_MATCH_DONE);
            r.tq = matched[30:0];
            rs.insert(rs.size(), r);
        end
        n = rs.size();
        foreach (rs[k]) begin
            rs[k].total = (book_qty > 37'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : book_qty[35:0];
            rs[k].count = 6'(book_cnt);
            rs[k].last  = (k == n - 1);
            pending_q.insert(pending_q.size(), rs[k]);
        end
    endtask

    // send one order after a random gap; valid stays up until the next gap or drain
    task automatic send_order(input t_order o);
        int gap_cycles;
        gap_cycles = $urandom_range(0, 14);
        if (gap_cycles != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap_cycles) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= o.op;
        in_ch.ord_key      <= o.oid;
        in_ch.quantity     <= o.qty;
        in_ch.order_active <= o.act;
        in_ch.aggr_side    <= o.side;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        book_step(o);
        @(negedge i_clk);
    endtask

    task automatic drain_and_write(input logic [31:0] price);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= price;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        book_price = price;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_id();
        if (used_ids.size() != 0 && $urandom_range(0, 3) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom;
    endfunction

    function automatic t_order rand_order();
        t_order o;
        int sel;
        sel = $urandom_range(0, 99);
        o.oid  = pick_id();
        o.act  = ($urandom_range(0, 7) != 0);
        o.side = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       o.qty = 31'($urandom);
            1:       o.qty = 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
            2:       o.qty = 0;
            default: o.qty = 31'($urandom_range(1, 200));
        endcase
        if (sel < 50) begin
            o.op = OP_ADD;
            used_ids.insert(used_ids.size(), o.oid);
        end else if (sel < 70) begin
            o.op = OP_CANCEL;
        end else begin
            o.op = OP_MATCH;
            if (o.qty > 1000 && $urandom_range(0, 1)) o.qty = 31'($urandom_range(1, 600));
        end
        return o;
    endfunction

    // directed table: add/cancel/match extremes and special cases
    t_order dir_tab[16] = '{
        '{OP_CANCEL, 32'h0000_0001, 31'd0,          1'b1, 1'b0},
        '{OP_MATCH,  32'hFFFF_FFFF, 31'd50,         1'b0, 1'b1},
        '{OP_ADD,    32'h0000_0000, 31'h7FFF_FFFF,  1'b1, 1'b0},
        '{OP_ADD,    32'hFFFF_FFFF, 31'h7FFF_FFFF,  1'b1, 1'b1},
        '{OP_ADD,    32'h0000_0011, 31'd0,          1'b1, 1'b0},
        '{OP_ADD,    32'h0000_0012, 31'd40,         1'b0, 1'b0},
        '{OP_ADD,    32'h0000_0013, 31'd25,         1'b1, 1'b0},
        '{OP_ADD,    32'h0000_0013, 31'd30,         1'b1, 1'b0},
        '{OP_CANCEL, 32'h0000_0013, 31'd0,          1'b0, 1'b0},
        '{OP_CANCEL, 32'h0000_0012, 31'd0,          1'b0, 1'b0},
        '{OP_CANCEL, 32'hFFFF_FFFF, 31'd0,          1'b0, 1'b0},
        '{OP_MATCH,  32'hAAAA_5555, 31'd0,          1'b1, 1'b0},
        '{OP_MATCH,  32'h5555_AAAA, 31'd10,         1'b0, 1'b0},
        '{OP_MATCH,  32'h1234_5678, 31'h7FFF_FFFF,  1'b0, 1'b1},
        '{OP_MATCH,  32'h8765_4321, 31'h7FFF_FFFF,  1'b1, 1'b0},
        '{OP_MATCH,  32'h0000_0007, 31'h7FFF_FFFF,  1'b0, 1'b1}
    };

    // result side: random wait before each result transfer
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 14);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result kind %0d", out_ch.result_kind);
            end else begin
                t_fill_rec e;
                e = pending_q[0];
                pending_q.delete(0);
                if (out_ch.result_kind !== e.kind || out_ch.status !== e.status
                        || out_ch.buyer_key !== e.buy_id
                        || out_ch.seller_key !== e.sell_id
                        || out_ch.resting_key !== e.rest_id
                        || out_ch.trade_quantity !== e.tq
                        || out_ch.fill_price !== e.price
                        || out_ch.resting_retired !== e.retired
                        || out_ch.level_qty !== e.total
                        || out_ch.live_orders !== e.count || out_ch.last !== e.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp k%0d s%0d b%h s%h r%h q%0d p%h x%b t%0d c%0d l%b got k%0d s%0d b%h s%h r%h q%0d p%h x%b t%0d c%0d l%b",
                            e.kind, e.status, e.buy_id, e.sell_id, e.rest_id, e.tq, e.price,
                            e.retired, e.total, e.count, e.last,
                            out_ch.result_kind, out_ch.status, out_ch.buyer_key,
                            out_ch.seller_key, out_ch.resting_key,
                            out_ch.trade_quantity, out_ch.fill_price, out_ch.resting_retired,
                            out_ch.level_qty, out_ch.live_orders, out_ch.last);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !done_flag) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_order o;
        errors = 0; mismatches = 0; idle_cycles = 0; done_flag = 0;
        book_head = 0; book_tail = 0; book_occ = 0; book_cnt = 0;
        book_qty = 0; book_price = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.kind = OP_ADD; in_ch.ord_key = '0;
        in_ch.quantity = '0; in_ch.order_active = 1'b0; in_ch.aggr_side = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first two rows read directly: cancel on empty, match on empty
        for (int i = 0; i < $size(dir_tab); i++) begin
            if (i == 2) drain_and_write(32'hFFFF_FFFF);
            if (i == 12) drain_and_write(32'h0000_0000);
            send_order(dir_tab[i]);
            if (i == 0 && (pending_q[0].kind != RK_CANCEL_ACK
                    || pending_q[0].status != ST_NOT_FOUND)) errors++;
            if (i == 1 && pending_q[$].kind != RK_MATCH_DONE) errors++;
        end
        // fill the ring to overflow
        drain_and_write(32'h8000_0001);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
            o = '{OP_ADD, 32'(i + 100), 31'($urandom_range(1, 9)), 1'b1, 1'b0};
            send_order(o);
        end
        o = '{OP_MATCH, 32'h0BAD_F00D, 31'h7FFF_FFFF, 1'b0, 1'b1};
        send_order(o);
        // random phase with a few price changes
        for (int i = 0; i < 230; i++) begin
            if (i % 70 == 69) drain_and_write($urandom);
            send_order(rand_order());
        end
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        done_flag = 1;
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
